// ===== design/jac_pkg.sv =====
package jac_pkg;

   localparam int SampleWidth   = 10;
   localparam int PosWidth      = 11;
   localparam int ValueWidth    = 9;
   localparam int MagWidth      = 8;
   localparam int SumWidth      = 17;
   localparam int CountWidth    = 7;
   localparam int DividendWidth = 18;
   localparam int StepWidth     = 5;
   localparam int IndexWidth    = 3;
   localparam int DataWidth     = 11;

   localparam logic [CountWidth:0]      CalSamples   = 8'd100;
   localparam logic [MagWidth-1:0]      FullScale    = 8'd255;
   localparam logic [SampleWidth-1:0]   CentreReset  = 10'd512;
   localparam logic [PosWidth-1:0]      MaxPosReset  = 11'd1024;
   localparam logic [StepWidth-1:0]     LastStep     = 5'(DividendWidth - 1);

   typedef enum logic [IndexWidth-1:0] {
      REG_MAX_POSITION     = 3'd0,
      REG_INVERT_DIRECTION = 3'd1,
      REG_MIN_CHANGE       = 3'd2,
      REG_DEAD_ZONE        = 3'd3,
      REG_MAX_VALUE        = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   function automatic logic [SampleWidth-1:0] abs_diff(
      input logic [SampleWidth-1:0] a,
      input logic [SampleWidth-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== design/joystick_axis_conditioner_core.sv =====
// a word needing no division goes idle, eval, done; a division-scaled run word
// or the calibration word completing the centre mean also passes the divide
// state, where a restoring divider forms the quotient one bit per cycle
// one word is in flight at a time; the response register frees the input side
// reset (synchronous, active high) restores the default registers, centre 512,
// clears tracking, calibration sum and count, and empties the response register
module joystick_axis_conditioner_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [jac_pkg::SampleWidth-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [jac_pkg::ValueWidth-1:0] rsp_axis_value,
   output logic                           rsp_updated,
   output logic                           rsp_centre_ready,
   input  logic                           csr_we,
   input  logic [jac_pkg::IndexWidth-1:0] csr_index,
   input  logic [jac_pkg::DataWidth-1:0]  csr_wdata
);
   import jac_pkg::*;

   state_type state_ff, state_in;

   logic [PosWidth-1:0]    max_position_ff;
   logic                   invert_direction_ff;
   logic [SampleWidth-1:0] min_change_ff;
   logic [SampleWidth-1:0] dead_zone_ff;
   logic [MagWidth-1:0]    max_value_ff;

   logic [SampleWidth-1:0] last_position_ff, last_position_in;
   logic                   position_valid_ff, position_valid_in;
   logic [ValueWidth-1:0]  held_value_ff, held_value_in;
   logic [SampleWidth-1:0] centre_ff, centre_in;
   logic [SumWidth-1:0]    cal_sum_ff, cal_sum_in;
   logic [CountWidth-1:0]  cal_count_ff, cal_count_in;

   logic                   mode_ff, mode_in;
   logic [SampleWidth-1:0] sample_ff, sample_in;

   logic                   p_updated_ff, p_updated_in;
   logic                   p_ready_ff, p_ready_in;
   logic                   p_scaled_ff, p_scaled_in;
   logic                   p_zero_ff, p_zero_in;
   logic                   p_neg_ff, p_neg_in;

   logic [DividendWidth-1:0] dvd_ff, dvd_in;
   logic [PosWidth-1:0]      divisor_ff, divisor_in;
   logic [PosWidth-1:0]      rem_ff, rem_in;
   logic [StepWidth-1:0]     step_ff, step_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_updated_ff, rsp_updated_in;
   logic                   rsp_ready_flag_ff, rsp_ready_flag_in;

   logic [PosWidth:0]        rem_shift;
   logic [PosWidth:0]        rem_diff;
   logic                     qbit;
   logic [CountWidth:0]      count_next;
   logic [SumWidth-1:0]      sum_next;
   logic [SampleWidth-1:0]   distance;
   logic [PosWidth:0]        span_high;
   logic [DividendWidth-1:0] dist_scaled;
   logic [MagWidth-1:0]      mag;
   logic [MagWidth-1:0]      mag_clamped;
   logic [ValueWidth-1:0]    value_out;
   logic                     out_free;
   logic                     take_run;
   logic                     above;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_position_ff     <= MaxPosReset;
         invert_direction_ff <= 1'b0;
         min_change_ff       <= 10'd10;
         dead_zone_ff        <= 10'd10;
         max_value_ff        <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_POSITION:     max_position_ff     <= csr_wdata;
            REG_INVERT_DIRECTION: invert_direction_ff <= csr_wdata[0];
            REG_MIN_CHANGE:       min_change_ff       <= csr_wdata[SampleWidth-1:0];
            REG_DEAD_ZONE:        dead_zone_ff        <= csr_wdata[SampleWidth-1:0];
            REG_MAX_VALUE:        max_value_ff        <= csr_wdata[MagWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         last_position_ff  <= '0;
         position_valid_ff <= 1'b0;
         held_value_ff     <= '0;
         centre_ff         <= CentreReset;
         cal_sum_ff        <= '0;
         cal_count_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         last_position_ff  <= last_position_in;
         position_valid_ff <= position_valid_in;
         held_value_ff     <= held_value_in;
         centre_ff         <= centre_in;
         cal_sum_ff        <= cal_sum_in;
         cal_count_ff      <= cal_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff           <= mode_in;
      sample_ff         <= sample_in;
      p_updated_ff      <= p_updated_in;
      p_ready_ff        <= p_ready_in;
      p_scaled_ff       <= p_scaled_in;
      p_zero_ff         <= p_zero_in;
      p_neg_ff          <= p_neg_in;
      dvd_ff            <= dvd_in;
      divisor_ff        <= divisor_in;
      rem_ff            <= rem_in;
      step_ff           <= step_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_updated_ff    <= rsp_updated_in;
      rsp_ready_flag_ff <= rsp_ready_flag_in;
   end

   // restoring divider step
   assign rem_shift = {rem_ff, dvd_ff[DividendWidth-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign qbit      = (rem_shift >= {1'b0, divisor_ff});

   assign count_next  = {1'b0, cal_count_ff} + 1'b1;
   assign sum_next    = cal_sum_ff + {{(SumWidth-SampleWidth){1'b0}}, sample_ff};
   assign take_run    = !position_valid_ff || (abs_diff(sample_ff, last_position_ff) > min_change_ff);
   assign above       = sample_ff > centre_ff;
   assign distance    = abs_diff(sample_ff, centre_ff);
   assign span_high   = {1'b0, max_position_ff} - {2'b00, centre_ff};
   assign dist_scaled = {distance, 8'd0} - {8'd0, distance};

   assign mag         = (|dvd_ff[DividendWidth-1:MagWidth]) ? FullScale : dvd_ff[MagWidth-1:0];
   assign mag_clamped = (mag > max_value_ff) ? max_value_ff : mag;

   always_comb begin
      if (p_zero_ff) begin
         value_out = '0;
      end else if (p_scaled_ff) begin
         value_out = p_neg_ff ? (ValueWidth'(0) - {1'b0, mag_clamped}) : {1'b0, mag_clamped};
      end else begin
         value_out = held_value_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      last_position_in  = last_position_ff;
      position_valid_in = position_valid_ff;
      held_value_in     = held_value_ff;
      centre_in         = centre_ff;
      cal_sum_in        = cal_sum_ff;
      cal_count_in      = cal_count_ff;
      mode_in           = mode_ff;
      sample_in         = sample_ff;
      p_updated_in      = p_updated_ff;
      p_ready_in        = p_ready_ff;
      p_scaled_in       = p_scaled_ff;
      p_zero_in         = p_zero_ff;
      p_neg_in          = p_neg_ff;
      dvd_in            = dvd_ff;
      divisor_in        = divisor_ff;
      rem_in            = rem_ff;
      step_in           = step_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_value_in      = rsp_value_ff;
      rsp_updated_in    = rsp_updated_ff;
      rsp_ready_flag_in = rsp_ready_flag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               sample_in = req_sample;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            p_updated_in = 1'b0;
            p_ready_in   = 1'b0;
            p_scaled_in  = 1'b0;
            p_zero_in    = 1'b0;
            p_neg_in     = 1'b0;
            rem_in       = '0;
            step_in      = LastStep;
            state_in     = ST_DONE;
            if (mode_ff) begin
               if (count_next >= CalSamples) begin
                  cal_sum_in   = '0;
                  cal_count_in = '0;
                  p_ready_in   = 1'b1;
                  dvd_in       = {{(DividendWidth-SumWidth){1'b0}}, sum_next};
                  divisor_in   = PosWidth'(CalSamples);
                  state_in     = ST_DIVIDE;
               end else begin
                  cal_sum_in   = sum_next;
                  cal_count_in = count_next[CountWidth-1:0];
               end
            end else if (take_run) begin
               position_valid_in = 1'b1;
               p_updated_in      = 1'b1;
               if (distance < dead_zone_ff) begin
                  last_position_in = centre_ff;
                  p_zero_in        = 1'b1;
               end else begin
                  last_position_in = sample_ff;
                  if (distance == '0) begin
                     p_zero_in = 1'b1;
                  end else begin
                     p_scaled_in = 1'b1;
                     p_neg_in    = (!above) ^ invert_direction_ff;
                     if (above && (span_high[PosWidth] || span_high == '0)) begin
                        dvd_in = {{(DividendWidth-MagWidth){1'b0}}, FullScale};
                     end else begin
                        dvd_in     = dist_scaled;
                        divisor_in = above ? span_high[PosWidth-1:0] : {1'b0, centre_ff};
                        state_in   = ST_DIVIDE;
                     end
                  end
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = qbit ? rem_diff[PosWidth-1:0] : rem_shift[PosWidth-1:0];
            dvd_in  = {dvd_ff[DividendWidth-2:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (p_ready_ff) begin
                  centre_in = dvd_ff[SampleWidth-1:0];
               end
               if (p_updated_ff) begin
                  held_value_in = value_out;
               end
               rsp_valid_in      = 1'b1;
               rsp_value_in      = value_out;
               rsp_updated_in    = p_updated_ff;
               rsp_ready_flag_in = p_ready_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_value   = rsp_value_ff;
   assign rsp_updated      = rsp_updated_ff;
   assign rsp_centre_ready = rsp_ready_flag_ff;

endmodule

// ===== design/jac_checker.sv =====
module jac_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [jac_pkg::ValueWidth-1:0] rsp_axis_value,
   input logic                           rsp_updated,
   input logic                           rsp_centre_ready
);
   import jac_pkg::*;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one word in flight
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a word is in flight");

   // a word is never both a run update and a calibration completion
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_updated && rsp_centre_ready))
      else $error("updated and centre_ready both set");

   // the magnitude never exceeds full scale
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_axis_value != {1'b1, {(ValueWidth-1){1'b0}}}))
      else $error("axis value out of range");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_axis_value)))
      else $error("stalled response changed");

endmodule

bind joystick_axis_conditioner_core jac_checker u_jac_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_axis_value   (rsp_axis_value),
   .rsp_updated      (rsp_updated),
   .rsp_centre_ready (rsp_centre_ready)
);
